/* rtl/core/tracker_cell_packer_core_assert.svh */
// Assertion macros used by the packer core RTL.
`ifndef TRACKER_CELL_PACKER_CORE_ASSERT_SVH
`define TRACKER_CELL_PACKER_CORE_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define TCPACK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define TCPACK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/tcpack_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpack_pkg
// Types, codes and the period table of the tracker cell packer.
// ----------------------------------------------------------------------------
package tcpack_pkg;

  localparam int PERIOD_ENTRIES = 36;

  // One pattern cell as it arrives
  typedef struct packed {
    logic [11:0] period;
    logic [4:0]  instrument;
    logic [3:0]  effect_cmd;
    logic [7:0]  effect_param;
  } cell_t;

  // One packed cell as it leaves
  typedef struct packed {
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [1:0]  byte_count;
    logic [31:0] feature_mask;
  } code_t;

  // Effect commands
  localparam logic [3:0] CMD_ARP       = 4'd0;
  localparam logic [3:0] CMD_SLIDE_UP  = 4'd1;
  localparam logic [3:0] CMD_SLIDE_DN  = 4'd2;
  localparam logic [3:0] CMD_ALT_ARP   = 4'd8;
  localparam logic [3:0] CMD_VOLUME    = 4'd12;
  localparam logic [3:0] CMD_EXT       = 4'd14;

  // Extended subcommands
  localparam logic [3:0] SUB_FILTER     = 4'd0;
  localparam logic [3:0] SUB_FINE_UP    = 4'd1;
  localparam logic [3:0] SUB_FINE_DN    = 4'd2;
  localparam logic [3:0] SUB_ARP        = 4'd8;
  localparam logic [3:0] SUB_RETRIG     = 4'd9;
  localparam logic [3:0] SUB_VOL_UP     = 4'd10;
  localparam logic [3:0] SUB_VOL_DN     = 4'd11;
  localparam logic [3:0] SUB_CUT        = 4'd12;
  localparam logic [3:0] SUB_NOTE_DELAY = 4'd13;
  localparam logic [3:0] SUB_ROW_DELAY  = 4'd14;

  localparam logic [7:0] VOLUME_MAX    = 8'd64;

  // Layout tags and byte counts
  localparam logic [7:0] EMPTY_CODE    = 8'h7f;
  localparam logic [4:0] NOTE_TAG      = 5'b01110;
  localparam logic [3:0] CMD_TAG       = 4'h6;
  localparam logic [1:0] COUNT_EMPTY   = 2'd1;
  localparam logic [1:0] COUNT_SHORT   = 2'd2;
  localparam logic [1:0] COUNT_FULL    = 2'd3;

  localparam logic [11:0] NOTE_PERIODS [PERIOD_ENTRIES] = '{
    12'd856, 12'd808, 12'd762, 12'd720, 12'd678, 12'd640,
    12'd604, 12'd570, 12'd538, 12'd508, 12'd480, 12'd453,
    12'd428, 12'd404, 12'd381, 12'd360, 12'd339, 12'd320,
    12'd302, 12'd285, 12'd269, 12'd254, 12'd240, 12'd226,
    12'd214, 12'd202, 12'd190, 12'd180, 12'd170, 12'd160,
    12'd151, 12'd143, 12'd135, 12'd127, 12'd120, 12'd113
  };

  // Note index 1..36 by exact match, 0 when the period is not listed
  function automatic logic [5:0] note_of(input logic [11:0] period);
    logic [5:0] note;
    note = 6'd0;
    for (int k = PERIOD_ENTRIES - 1; k >= 0; k--) begin
      if (NOTE_PERIODS[k] == period) begin
        note = 6'(k + 1);
      end
    end
    return note;
  endfunction

endpackage

/* rtl/core/tcpack_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpack_if
// Valid/ready channels for incoming cells and outgoing packed codes.
// ----------------------------------------------------------------------------
interface tcpack_cell_if;
  logic              valid;
  logic              ready;
  tcpack_pkg::cell_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcpack_code_if;
  logic              valid;
  logic              ready;
  tcpack_pkg::code_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/tracker_cell_packer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_cell_packer_core
// Packs tracker pattern cells into 1 to 3 bytes and tracks used effects.
// ----------------------------------------------------------------------------
// Usage:
//   cells : one request per pattern cell (period, instrument, effect command,
//           effect parameter), taken when valid and ready are both high.
//   code  : one request per cell with the packed bytes, the byte count and
//           the running effect mask after that cell, in arrival order.
//   An accepted cell is held in the input register while the period lookup,
//   effect remap and packing settle, and is loaded into the output register
//   when that register is free or being emptied.
//   Throughput is one cell per cycle while the receiver takes each code; the
//   single pass of compare and bit packing between the two registers sets
//   that figure.
//   When the receiver stalls, the output register holds its code and the
//   input register still takes one more cell; only when both are full does
//   cells.ready fall.
//   Reset empties both registers and clears the effect mask. Bit 0 of the
//   mask is never set here.
// ----------------------------------------------------------------------------
`include "tracker_cell_packer_core_assert.svh"

module tracker_cell_packer_core (
  input  logic                 clk,
  input  logic                 rst,
  tcpack_cell_if.sink          cells,
  tcpack_code_if.source        code
);

  logic              s1_valid;
  tcpack_pkg::cell_t s1_cell;
  logic              out_valid;
  tcpack_pkg::code_t out_code;
  logic [31:0]       used_effects;

  logic              s1_advance;

  logic [5:0]        note;
  logic [3:0]        sub;
  logic [3:0]        val;
  logic [3:0]        cmd_r;
  logic [7:0]        prm_r;
  logic [3:0]        sub_r;
  logic              used;
  logic [31:0]       mask_bit;
  logic [31:0]       mask_next;
  tcpack_pkg::code_t code_next;

  // Handshake: move on when the output register is free or being emptied
  assign s1_advance  = s1_valid && (!out_valid || code.ready);
  assign cells.ready = !s1_valid || s1_advance;
  assign code.valid  = out_valid;
  assign code.data   = out_code;

  // Remap the effect
  always_comb begin
    note  = tcpack_pkg::note_of(s1_cell.period);
    sub   = s1_cell.effect_param[7:4];
    val   = s1_cell.effect_param[3:0];
    cmd_r = s1_cell.effect_cmd;
    prm_r = s1_cell.effect_param;
    sub_r = sub;
    used  = (s1_cell.effect_cmd != tcpack_pkg::CMD_ARP) || (s1_cell.effect_param != 8'd0);
    case (s1_cell.effect_cmd)
      tcpack_pkg::CMD_ARP: begin
        if (s1_cell.effect_param != 8'd0) begin
          cmd_r = tcpack_pkg::CMD_ALT_ARP;
        end
      end
      tcpack_pkg::CMD_SLIDE_UP, tcpack_pkg::CMD_SLIDE_DN: begin
        used = s1_cell.effect_param != 8'd0;
      end
      tcpack_pkg::CMD_VOLUME: begin
        if (s1_cell.effect_param > tcpack_pkg::VOLUME_MAX) begin
          prm_r = tcpack_pkg::VOLUME_MAX;
        end
      end
      tcpack_pkg::CMD_ALT_ARP: begin
        cmd_r = tcpack_pkg::CMD_EXT;
        sub_r = tcpack_pkg::SUB_ARP;
        prm_r = {tcpack_pkg::SUB_ARP, val};
      end
      tcpack_pkg::CMD_EXT: begin
        case (sub)
          tcpack_pkg::SUB_FILTER: begin
            prm_r = {6'd0, val[0], 1'b0};
          end
          tcpack_pkg::SUB_CUT: begin
            if (val == 4'd0) begin
              cmd_r = tcpack_pkg::CMD_VOLUME;
              prm_r = 8'd0;
            end
          end
          default: begin
            // Drop zero-value subcommands that do nothing
            if (sub inside {tcpack_pkg::SUB_FINE_UP, tcpack_pkg::SUB_FINE_DN,
                            tcpack_pkg::SUB_RETRIG, tcpack_pkg::SUB_VOL_UP,
                            tcpack_pkg::SUB_VOL_DN, tcpack_pkg::SUB_NOTE_DELAY,
                            tcpack_pkg::SUB_ROW_DELAY}) begin
              used = val != 4'd0;
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    // Mark the effect in use, or clear a dropped one
    mask_bit = 32'd0;
    if (used) begin
      if (cmd_r == tcpack_pkg::CMD_EXT) begin
        mask_bit[{1'b1, sub_r}] = 1'b1;
      end else begin
        mask_bit[{1'b0, cmd_r}] = 1'b1;
      end
    end else begin
      cmd_r = tcpack_pkg::CMD_ARP;
      prm_r = 8'd0;
    end
    mask_next = used_effects | mask_bit;
  end

  // Pick the layout and pack the bytes
  always_comb begin
    code_next.feature_mask = mask_next;
    if (note == 6'd0 && s1_cell.instrument == 5'd0 && !used) begin
      code_next.byte0      = tcpack_pkg::EMPTY_CODE;
      code_next.byte1      = 8'd0;
      code_next.byte2      = 8'd0;
      code_next.byte_count = tcpack_pkg::COUNT_EMPTY;
    end else if (note != 6'd0 && s1_cell.instrument != 5'd0 && !used) begin
      code_next.byte0      = {tcpack_pkg::NOTE_TAG, note[5:3]};
      code_next.byte1      = {note[2:0], s1_cell.instrument};
      code_next.byte2      = 8'd0;
      code_next.byte_count = tcpack_pkg::COUNT_SHORT;
    end else if (note == 6'd0 && s1_cell.instrument == 5'd0 && used) begin
      code_next.byte0      = {tcpack_pkg::CMD_TAG, cmd_r};
      code_next.byte1      = prm_r;
      code_next.byte2      = 8'd0;
      code_next.byte_count = tcpack_pkg::COUNT_SHORT;
    end else begin
      code_next.byte0      = {1'b0, note, s1_cell.instrument[4]};
      code_next.byte1      = {s1_cell.instrument[3:0], cmd_r};
      code_next.byte2      = prm_r;
      code_next.byte_count = tcpack_pkg::COUNT_FULL;
    end
  end

  // Advance the control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      used_effects <= 32'd0;
    end else begin
      if (cells.ready) begin
        s1_valid <= cells.valid;
      end
      if (s1_advance) begin
        out_valid    <= 1'b1;
        used_effects <= mask_next;
      end else if (code.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the payload registers
  always_ff @(posedge clk) begin
    if (cells.valid && cells.ready) begin
      s1_cell <= cells.data;
    end
    if (s1_advance) begin
      out_code <= code_next;
    end
  end

  `TCPACK_ASSERT(a_count_nonzero, clk, rst, out_valid |-> out_code.byte_count != 2'd0, "byte count of zero on output")
  `TCPACK_ASSERT(a_empty_code, clk, rst, (out_valid && out_code.byte_count == tcpack_pkg::COUNT_EMPTY) |-> (out_code.byte0 == tcpack_pkg::EMPTY_CODE && out_code.byte1 == 8'd0), "empty cell packed wrongly")
  `TCPACK_ASSERT(a_mask_grows, clk, rst, !$past(rst) |-> ((used_effects & $past(used_effects)) == $past(used_effects)), "effect mask lost a bit")
  `TCPACK_ASSERT(a_cell_kept, clk, rst, (s1_valid && !s1_advance) |=> s1_valid, "stalled cell dropped")
  `TCPACK_ASSERT_ALWAYS(a_finetone_clear, clk, rst || !used_effects[0], "finetone bit set in effect mask")

endmodule
